### sv/edit_distance_engine_core_macros.svh
// Assertion macros shared by the edit distance engine RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef EDIT_DISTANCE_ENGINE_CORE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ED_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edit distance engine check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edit distance engine check failed");
`else
`define ED_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### sv/ed_pkg.sv
// Shared types and constants for the edit distance engine.
// Depends on nothing; used by the interfaces, the cell and the top level.
package ed_pkg;

    localparam int CHAR_W = 8;
    localparam int OP_W   = 2;
    localparam int DIST_W = 7;

    localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

    // Control that travels alongside each row of the wavefront.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CHAR_W-1:0] ch;
    } t_wave_ctl;

endpackage

### sv/ed_cmd_if.sv
// Command channel of the edit distance engine: opcode and character.
// Depends on ed_pkg for the field widths.
interface ed_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [ed_pkg::OP_W-1:0]    opcode;
    logic [ed_pkg::CHAR_W-1:0]  char_value;

    modport source (output valid, output opcode, output char_value, input ready);
    modport sink   (input valid, input opcode, input char_value, output ready);
endinterface

### sv/ed_res_if.sv
// Result channel of the edit distance engine: distance and overflow flag.
// Depends on ed_pkg for the field widths.
interface ed_res_if;
    logic                       valid;
    logic                       ready;
    logic [ed_pkg::DIST_W-1:0]  distance;
    logic                       overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

### sv/ed_cell.sv
// One column cell of the edit distance chain: holds one character of the
// second string and its column cost. Depends on ed_pkg for t_wave_ctl.
module ed_cell #(
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_init,
    input  logic                      i_wr_en,
    input  logic [CW-1:0]             i_wr_idx,
    input  logic [ed_pkg::CHAR_W-1:0] i_wr_char,
    input  logic [CW-1:0]             i_col_cnt,
    input  ed_pkg::t_wave_ctl         i_ctl,
    input  logic [CW-1:0]             i_left,
    input  logic [CW-1:0]             i_diag,
    output ed_pkg::t_wave_ctl         o_ctl,
    output logic [CW-1:0]             o_left,
    output logic [CW-1:0]             o_diag
);

    localparam logic [CW-1:0] INIT_COST = CW'(IDX + 1);

    logic [ed_pkg::CHAR_W-1:0] r_ch;
    logic [CW-1:0]             r_up;
    ed_pkg::t_wave_ctl         r_ctl;
    logic [CW-1:0]             r_left;
    logic [CW-1:0]             r_diag;

    logic          w_active;
    logic [CW-1:0] w_min2;
    logic [CW-1:0] w_min3;
    logic [CW-1:0] w_cost;

    // Cells past the end of the second string only forward the row cost.
    assign w_active = CW'(IDX) < i_col_cnt;
    assign w_min2   = (i_diag < r_up) ? i_diag : r_up;
    assign w_min3   = (w_min2 < i_left) ? w_min2 : i_left;
    assign w_cost   = (i_ctl.ch == r_ch) ? i_diag : w_min3 + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == CW'(IDX))) begin
            r_ch <= i_wr_char;
        end
        if (i_init) begin
            r_up <= INIT_COST;
        end else if (i_ctl.valid && w_active) begin
            r_up <= w_cost;
        end
        if (i_ctl.valid) begin
            r_left <= w_active ? w_cost : i_left;
            r_diag <= r_up;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_left = r_left;
    assign o_diag = r_diag;

endmodule

### sv/edit_distance_engine_core.sv
// Top level of the edit distance engine: string loading, row sequencer and
// the cell chain. Depends on ed_pkg, ed_cmd_if, ed_res_if, ed_cell and the macros header.
//
//  Channel  | Dir | Fields               | Beat accepted when
//  ---------+-----+----------------------+---------------------------
//  i_cmd    | in  | opcode, char_value   | i_cmd.valid && i_cmd.ready
//  o_res    | out | distance, overflow   | o_res.valid && o_res.ready
//
// An append beat takes one cycle and may be taken while a result is still waiting.
// A compute beat with n > 0 first-string characters presents its result as the engine
// leaves the hold state, when the command channel also reopens: n rows leave the memory
// one per cycle, and the wavefront crosses the chain of MAX_LEN cells, one cell per cycle.
// With an empty first string the engine goes straight to the hold state. Reset is synchronous
// and active low; it empties both strings and clears the flag. A stalled result holds the
// engine before it returns to idle.

`include "edit_distance_engine_core_macros.svh"

module edit_distance_engine_core #(
    parameter int MAX_LEN = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ed_cmd_if.sink       i_cmd,
    ed_res_if.source     o_res
);

    // Cost width holds any distance up to MAX_LEN; address width indexes the memory.
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FEED  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_len_a, n_len_a;
    logic [CW-1:0] r_len_b, n_len_b;
    logic          r_flag,  n_flag;
    logic [CW-1:0] r_rd,    n_rd;
    logic [CW-1:0] r_res,   n_res;

    logic                      r_out_vld;
    logic [ed_pkg::DIST_W-1:0] r_out_dist;
    logic                      r_out_ovf;

    // Row source feeding the first cell.
    logic                      r_src_vld;
    logic                      r_src_last;
    logic [CW-1:0]             r_src_row;
    logic [ed_pkg::CHAR_W-1:0] r_src_ch;

    // First string store; only entries below the length are ever read.
    logic [ed_pkg::CHAR_W-1:0] r_mem_a [0:MAX_LEN-1];

    logic w_cmd_acc;
    logic w_app_a;
    logic w_app_b;
    logic w_compute;
    logic w_rd_en;
    logic w_init;
    logic w_out_free;
    logic w_tail_done;
    logic [31:0]               w_res_ext;
    logic [ed_pkg::DIST_W-1:0] w_res_sat;

    ed_pkg::t_wave_ctl w_ctl  [0:MAX_LEN];
    logic [CW-1:0]     w_left [0:MAX_LEN];
    logic [CW-1:0]     w_diag [0:MAX_LEN];

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_cmd_acc   = i_cmd.valid && i_cmd.ready;
    assign w_app_a     = w_cmd_acc && (i_cmd.opcode == ed_pkg::OP_APPEND_FIRST);
    assign w_app_b     = w_cmd_acc && (i_cmd.opcode == ed_pkg::OP_APPEND_SECOND);
    assign w_compute   = w_cmd_acc && (i_cmd.opcode == ed_pkg::OP_COMPUTE);
    assign w_rd_en     = (r_state == S_FEED);
    // Column costs are reset to the first DP row whenever a sweep starts.
    assign w_init      = w_compute;
    assign w_out_free  = !r_out_vld || o_res.ready;
    assign w_tail_done = w_ctl[MAX_LEN].valid && w_ctl[MAX_LEN].last;

    // Distances above the seven-bit field saturate.
    assign w_res_ext = 32'(r_res);
    assign w_res_sat = (w_res_ext > 32'(ed_pkg::DIST_MAX)) ? ed_pkg::DIST_MAX
                                                            : w_res_ext[ed_pkg::DIST_W-1:0];

    always_comb begin
        n_state = r_state;
        n_len_a = r_len_a;
        n_len_b = r_len_b;
        n_flag  = r_flag;
        n_rd    = r_rd;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_app_a) begin
                    if (r_len_a < LEN_MAX) begin
                        n_len_a = r_len_a + CW'(1);
                    end else begin
                        n_flag = 1'b1;
                    end
                end
                if (w_app_b) begin
                    if (r_len_b < LEN_MAX) begin
                        n_len_b = r_len_b + CW'(1);
                    end else begin
                        n_flag = 1'b1;
                    end
                end
                if (w_compute) begin
                    n_rd = '0;
                    if (r_len_a == '0) begin
                        // With no rows the distance is the second string's length.
                        n_res   = r_len_b;
                        n_state = S_HOLD;
                    end else begin
                        n_state = S_FEED;
                    end
                end
            end
            S_FEED: begin
                n_rd = r_rd + CW'(1);
                if ((r_rd + CW'(1)) == r_len_a) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_tail_done) begin
                    n_res   = w_left[MAX_LEN];
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_len_a = '0;
                    n_len_b = '0;
                    n_flag  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len_a   <= '0;
            r_len_b   <= '0;
            r_flag    <= 1'b0;
            r_rd      <= '0;
            r_out_vld <= 1'b0;
            r_src_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len_a   <= n_len_a;
            r_len_b   <= n_len_b;
            r_flag    <= n_flag;
            r_rd      <= n_rd;
            r_src_vld <= w_rd_en;
            if ((r_state == S_HOLD) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result payload and row source payload carry no reset.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if ((r_state == S_HOLD) && w_out_free) begin
            r_out_dist <= w_res_sat;
            r_out_ovf  <= r_flag;
        end
        if (w_rd_en) begin
            r_src_row  <= r_rd + CW'(1);
            r_src_last <= (r_rd + CW'(1)) == r_len_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_app_a && (r_len_a < LEN_MAX)) begin
            r_mem_a[r_len_a[AW-1:0]] <= i_cmd.char_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_src_ch <= r_mem_a[r_rd[AW-1:0]];
        end
    end

    // Row i enters with D[i][0] = i on the left and D[i-1][0] = i-1 on the diagonal.
    assign w_ctl[0].valid = r_src_vld;
    assign w_ctl[0].last  = r_src_last;
    assign w_ctl[0].ch    = r_src_ch;
    assign w_left[0]      = r_src_row;
    assign w_diag[0]      = r_src_row - CW'(1);

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        ed_cell #(
            .CW  (CW),
            .IDX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_init    (w_init),
            .i_wr_en   (w_app_b && (r_len_b < LEN_MAX)),
            .i_wr_idx  (r_len_b),
            .i_wr_char (i_cmd.char_value),
            .i_col_cnt (r_len_b),
            .i_ctl     (w_ctl[k]),
            .i_left    (w_left[k]),
            .i_diag    (w_diag[k]),
            .o_ctl     (w_ctl[k+1]),
            .o_left    (w_left[k+1]),
            .o_diag    (w_diag[k+1])
        );
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.distance = r_out_dist;
    assign o_res.overflow = r_out_ovf;

    // Neither string may ever count past its capacity.
    `ED_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, 1'b1, (r_len_a <= LEN_MAX) && (r_len_b <= LEN_MAX))
    // The last row may only leave the chain once all rows have been issued.
    `ED_ASSERT_NOW(a_tail_in_drain, i_clk, i_rst_n, w_tail_done, r_state == S_DRAIN)
    // A new result appears only as the hold state hands it over.
    `ED_ASSERT_NOW(a_res_from_hold, i_clk, i_rst_n, $rose(r_out_vld), $past(r_state) == S_HOLD)
    // Handing over a result empties both strings and clears the flag.
    `ED_ASSERT_NEXT(a_clear_after, i_clk, i_rst_n, (r_state == S_HOLD) && w_out_free, (r_len_a == '0) && (r_len_b == '0) && !r_flag)

endmodule

### sim/testbench.sv
// Self-checking testbench for edit_distance_engine_core: loads strings, asks for distances.
// Depends on ed_pkg, ed_cmd_if, ed_res_if and the engine RTL; needs no other file.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = 64;
    localparam int BEAT_TARGET = 2000;

    // The opcode space has one code that the engine must ignore.
    localparam logic [ed_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef logic [ed_pkg::CHAR_W-1:0] t_char;

    typedef struct packed {
        logic [ed_pkg::DIST_W-1:0] distance;
        logic                      overflow;
    } t_edit_result;

    // Mirrors the engine's strings and flag, and keeps the distances still owed by it.
    class distance_scoreboard #(int CAP = 64);
        t_char             first_str[CAP];
        t_char             second_str[CAP];
        int                first_len;
        int                second_len;
        bit                dropped;
        t_edit_result      pending_distances[$];
        int                fault_count;

        function new();
            first_len   = 0;
            second_len  = 0;
            dropped     = 1'b0;
            fault_count = 0;
        endfunction

        // Classic single-row dynamic programme over the kept characters.
        function logic [ed_pkg::DIST_W-1:0] levenshtein();
            int unsigned row[CAP+1];
            int unsigned diag;
            int unsigned up;
            int unsigned cost;
            int unsigned total;
            for (int j = 0; j <= second_len; j++) row[j] = j;
            for (int i = 1; i <= first_len; i++) begin
                diag = row[0];
                row[0] = i;
                for (int j = 1; j <= second_len; j++) begin
                    up = row[j];
                    if (first_str[i-1] == second_str[j-1]) begin
                        cost = diag;
                    end else begin
                        cost = diag;
                        if (up < cost) cost = up;
                        if (row[j-1] < cost) cost = row[j-1];
                        cost = cost + 1;
                    end
                    diag = up;
                    row[j] = cost;
                end
            end
            total = row[second_len];
            return (total > ed_pkg::DIST_MAX) ? ed_pkg::DIST_MAX : total[ed_pkg::DIST_W-1:0];
        endfunction

        function void note_command(logic [ed_pkg::OP_W-1:0] op, t_char ch);
            t_edit_result res;
            case (op)
                ed_pkg::OP_APPEND_FIRST: begin
                    if (first_len < CAP) begin
                        first_str[first_len] = ch;
                        first_len++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                ed_pkg::OP_APPEND_SECOND: begin
                    if (second_len < CAP) begin
                        second_str[second_len] = ch;
                        second_len++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                ed_pkg::OP_COMPUTE: begin
                    res.distance = levenshtein();
                    res.overflow = dropped;
                    pending_distances.push_back(res);
                    first_len  = 0;
                    second_len = 0;
                    dropped    = 1'b0;
                end
                default: begin
                end
            endcase
        endfunction

        task report(string what);
            fault_count++;
            if (fault_count <= 40) $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(logic [ed_pkg::DIST_W-1:0] distance, logic overflow);
            t_edit_result want;
            if (pending_distances.size() == 0) begin
                report("result beat with no distance outstanding");
            end else begin
                want = pending_distances.pop_front();
                if (distance !== want.distance)
                    report($sformatf("distance %0d, expected %0d", distance, want.distance));
                if (overflow !== want.overflow)
                    report($sformatf("overflow %0b, expected %0b", overflow, want.overflow));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ed_cmd_if cmd_bus ();
    ed_res_if res_bus ();

    edit_distance_engine_core #(
        .MAX_LEN (MAX_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    distance_scoreboard #(MAX_LEN) tracker;

    // Sender pacing: bursts of back-to-back beats, separated by random gaps when bursty.
    bit bursty;
    int burst_left;
    int beats_sent;

    // Receiver pacing: a rotating mask, replaced each time its eight-bit age counter wraps.
    logic [31:0] stall_pattern;
    logic [7:0]  stall_age;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The result channel stalls on its own schedule, independent of the sender. Some
    // masks never stall, some stall at random, and one sets only a single ready bit in its 32-bit mask.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_pattern <= '1;
            stall_age     <= '0;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= stall_pattern[0];
            stall_age     <= stall_age + 8'd1;
            if (stall_age == 8'hFF) begin
                case ($urandom_range(0, 3))
                    0: stall_pattern <= '1;
                    1: stall_pattern <= $urandom;
                    2: stall_pattern <= 32'h0000_0001;
                    default: stall_pattern <= $urandom | $urandom;
                endcase
            end else begin
                stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
            end
        end
    end

    // Every accepted result beat is checked against the oldest outstanding distance.
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            tracker.check_result(res_bus.distance, res_bus.overflow);
    end

    // Presents one command beat and returns at the edge that accepts it. Valid is left
    // high so that a following beat can go straight out in the next cycle.
    task automatic send_command(input logic [ed_pkg::OP_W-1:0] op, input t_char ch);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (bursty) begin
                cmd_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        cmd_bus.valid      <= 1'b1;
        cmd_bus.opcode     <= op;
        cmd_bus.char_value <= ch;
        do @(posedge i_clk); while (!cmd_bus.ready);
        tracker.note_command(op, ch);
        if (op != OP_UNUSED) beats_sent++;
    endtask

    // Holds the command channel quiet until every distance owed has come back, then
    // allows one full sweep of the cell chain for anything still in flight.
    task automatic wait_for_drain();
        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_distances.size() != 0);
        repeat (MAX_LEN + 8) @(posedge i_clk);
    endtask

    // One well-formed load: two strings of random length with interleaved appends, a
    // little noise from the unused opcode, and a closing compute. Most strings are short;
    // some fill the store and some run past it so that characters are dropped.
    task automatic load_and_compute();
        int first_goal;
        int second_goal;
        int first_done;
        int second_done;
        int pick;
        int spare;
        bit narrow;
        t_char base;
        t_char ch;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            first_goal  = $urandom_range(0, 6);
            second_goal = $urandom_range(0, 6);
        end else if (pick < 92) begin
            first_goal  = $urandom_range(0, MAX_LEN);
            second_goal = $urandom_range(0, MAX_LEN);
        end else begin
            // A full or overfull string, against either an empty one or another full or overfull one.
            first_goal  = MAX_LEN + $urandom_range(0, 3);
            second_goal = $urandom_range(0, 1) ? 0 : MAX_LEN + $urandom_range(0, 3);
            if ($urandom_range(0, 1)) begin
                spare       = first_goal;
                first_goal  = second_goal;
                second_goal = spare;
            end
        end
        // A narrow alphabet makes matches common, so the diagonal path gets exercised.
        narrow = ($urandom_range(0, 2) != 0);
        base   = t_char'($urandom);
        first_done  = 0;
        second_done = 0;
        while (first_done < first_goal || second_done < second_goal) begin
            if ($urandom_range(0, 29) == 0) send_command(OP_UNUSED, t_char'($urandom));
            ch = narrow ? base + t_char'($urandom_range(0, 3)) : t_char'($urandom);
            if (second_done >= second_goal ||
                    (first_done < first_goal && $urandom_range(0, 1) == 1)) begin
                send_command(ed_pkg::OP_APPEND_FIRST, ch);
                first_done++;
            end else begin
                send_command(ed_pkg::OP_APPEND_SECOND, ch);
                second_done++;
            end
        end
        send_command(ed_pkg::OP_COMPUTE, t_char'($urandom));
    endtask

    initial begin
        int loads;
        tracker = new();
        bursty     = 1'b0;
        burst_left = 0;
        beats_sent = 0;
        i_rst_n            <= 1'b0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.opcode     <= ed_pkg::OP_APPEND_FIRST;
        cmd_bus.char_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats: both strings empty, one side empty, extreme characters,
        // identical strings, a swapped pair and the ignored opcode.
        send_command(ed_pkg::OP_COMPUTE, 8'h00);
        send_command(ed_pkg::OP_APPEND_FIRST, 8'hFF);
        send_command(ed_pkg::OP_COMPUTE, 8'hFF);
        send_command(ed_pkg::OP_APPEND_SECOND, 8'h00);
        send_command(ed_pkg::OP_COMPUTE, 8'h00);
        send_command(ed_pkg::OP_APPEND_FIRST, 8'h41);
        send_command(ed_pkg::OP_APPEND_SECOND, 8'h41);
        send_command(ed_pkg::OP_COMPUTE, 8'h00);
        send_command(ed_pkg::OP_APPEND_FIRST, 8'h00);
        send_command(ed_pkg::OP_APPEND_FIRST, 8'hFF);
        send_command(ed_pkg::OP_APPEND_SECOND, 8'hFF);
        send_command(ed_pkg::OP_APPEND_SECOND, 8'h00);
        send_command(OP_UNUSED, 8'hA5);
        send_command(ed_pkg::OP_COMPUTE, 8'h00);
        send_command(OP_UNUSED, 8'h5A);
        send_command(ed_pkg::OP_COMPUTE, 8'hFF);
        wait_for_drain();

        // Random loads. Every so often the sender waits for the engine to empty out,
        // and about a quarter of the loads go out with no gaps at all.
        loads = 0;
        while (beats_sent < BEAT_TARGET) begin
            if (loads % 16 == 15) wait_for_drain();
            bursty = ($urandom_range(0, 3) != 0);
            load_and_compute();
            loads++;
        end
        wait_for_drain();

        if (tracker.fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // The whole run needs well under a tenth of this.
    initial begin
        #(1_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
